[sv/s2dec_pkg.sv]
// Shared types and constants for the signed integer to decimal text converter.
package s2dec_pkg;

  // Width of the input integer.
  localparam int unsigned VALUE_W = 32;
  // Number of decimal digits that cover any 32-bit magnitude.
  localparam int unsigned DIGITS = 10;
  localparam int unsigned BCD_W = 4 * DIGITS;
  // Width of the character code on the result channel.
  localparam int unsigned CHAR_W = 7;

  // ASCII codes that the converter emits.
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 7'd57;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

[sv/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, one character per result.
//
// Channel | Direction | tdata (low bit up)                 | tuser | tlast
// in_     | slave     | [31:0] value, signed               | -     | -
// out_    | master    | [6:0] char_code, [7] zero          | -     | last_char
//
// A value is taken while the sequencer is idle, then a shift-and-add-3 unit converts the
// magnitude to ten BCD digits, one bit a cycle.
// Leading zeros are dropped one digit a cycle, then a step finds the leading
// digit, then the characters leave one per cycle while out_tready is high:
// 1 to 11 of them.
// in_tready stays low while an item is being converted and sent.
// A stall on out_tready holds the current character until it is taken.
// Reset returns the sequencer to idle; the data registers are not cleared.
module signed_int_to_decimal_ascii
  import s2dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] char_code, [7] zero fill
  output logic        out_tlast   // last_char
);

  state_t             state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [3:0]         dig_left_r, dig_left_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [3:0]         top_digit;
  logic               out_fire;

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign out_fire  = out_tvalid && out_tready;

  // State and data registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    dig_left_r <= dig_left_nxt;
  end

  // Sequencer: next state, datapath control and channel outputs.
  always_comb begin
    state_nxt    = state_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    bcd_nxt      = bcd_r;
    cnt_nxt      = cnt_r;
    dig_left_nxt = dig_left_r;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    out_tdata    = {1'b0, CH_ZERO + {3'd0, top_digit}};
    out_tlast    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          // Magnitude as unsigned, so the most negative value is exact.
          neg_nxt   = in_tdata[VALUE_W-1];
          mag_nxt   = in_tdata[VALUE_W-1] ? (~in_tdata + 32'd1) : in_tdata;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // One binary bit moves into the BCD register per cycle.
        {bcd_nxt, mag_nxt} = {bcd_adj, mag_r} << 1;
        cnt_nxt            = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          dig_left_nxt = 4'(DIGITS);
          state_nxt    = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, always keeping the final digit.
        if (top_digit == 4'd0 && dig_left_r > 4'd1) begin
          bcd_nxt      = bcd_r << 4;
          dig_left_nxt = dig_left_r - 4'd1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_tvalid = 1'b1;
        out_tdata  = {1'b0, CH_MINUS};
        if (out_fire) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        out_tlast  = (dig_left_r == 4'd1);
        if (out_fire) begin
          bcd_nxt      = bcd_r << 4;
          dig_left_nxt = dig_left_r - 4'd1;
          if (dig_left_r == 4'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/s2dec_chk.sv]
// Port-level checker for the decimal text converter, bound to the top level.
module s2dec_chk
  import s2dec_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // The block never takes a request while it is sending characters.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a character is pending");

  // After a request is taken, the block is busy converting.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("not busy after taking a request");

  // Every character is a minus sign or a decimal digit.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == {1'b0, CH_MINUS} ||
                    (out_tdata >= {1'b0, CH_ZERO} && out_tdata <= {1'b0, CH_NINE})))
    else $error("character outside the decimal set");

  // A minus sign is always followed by at least one digit.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == {1'b0, CH_MINUS}) |-> !out_tlast)
    else $error("minus sign marked as last character");

  // A stalled character holds its value and marker.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled character changed");

endmodule

bind signed_int_to_decimal_ascii s2dec_chk u_s2dec_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/signed_int_to_decimal_ascii_tb.sv]
// Testbench for the signed integer to decimal ASCII converter: random traffic, self-checking.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
  import s2dec_pkg::*;

  // One character of decimal text as it should leave the block.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } text_char_t;

  // Cycle window with no idling on either side, and the long receiver hold-off.
  localparam int QUIET_START   = 6000;
  localparam int QUIET_END     = 10000;
  localparam int HOLDOFF_AT    = 2000;
  localparam int HOLDOFF_LEN   = 300;
  localparam int IDLE_PERCENT  = 18;
  localparam int RANDOM_VALUES = 280;
  localparam int DRAIN_CYCLES  = 60;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;

  logic [VALUE_W-1:0]    pending_values[$];
  text_char_t            expected_chars[$];
  int                    values_total;
  int                    values_sent = 0;
  int                    negatives_sent = 0;
  int                    chars_checked = 0;
  int                    failures = 0;
  int                    cycle_count = 0;
  int                    holdoff_left = 0;
  bit                    holdoff_done = 1'b0;
  bit [DIGITS+1:0]       run_lengths_seen = '0;

  signed_int_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Random idle decision shared by both sides, off inside the quiet window.
  function automatic bit roll_idle();
    if (cycle_count >= QUIET_START && cycle_count < QUIET_END) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < IDLE_PERCENT;
  endfunction

  // Works out the decimal text of one value and queues its characters.
  function automatic void predict_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] magnitude;
    logic [3:0]         digit_vals[DIGITS];
    int                 n_digits;
    int                 i;
    magnitude = value[VALUE_W-1] ? (32'd0 - value) : value;
    n_digits = 0;
    // Digits come out least significant first; zero still gives one digit.
    do begin
      digit_vals[n_digits] = 4'(magnitude % 32'd10);
      magnitude = magnitude / 32'd10;
      n_digits++;
    end while (magnitude != 0 && n_digits < DIGITS);
    if (value[VALUE_W-1]) begin
      expected_chars.push_back('{char_code: CH_MINUS, last_char: 1'b0});
      negatives_sent++;
    end
    for (i = n_digits - 1; i >= 0; i--) begin
      expected_chars.push_back('{char_code: CH_ZERO + 7'(digit_vals[i]),
                                 last_char: (i == 0)});
    end
    run_lengths_seen[n_digits + int'(value[VALUE_W-1])] = 1'b1;
  endfunction

  // Picks a random value, biased toward every text length and both signs.
  function automatic logic [VALUE_W-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int              n;
    int              k;
    case ($urandom_range(0, 3))
      0: begin
        return $urandom;
      end
      1: begin
        n = $urandom_range(1, DIGITS);
        lo = 1;
        for (k = 1; k < n; k++) begin
          lo = lo * 10;
        end
        hi = (n == DIGITS) ? 64'd2147483647 : lo * 10 - 1;
        if (n == 1) begin
          lo = 0;
        end
        mag = lo + ($urandom % (hi - lo + 1));
        return $urandom_range(0, 1) ? (32'd0 - 32'(mag)) : 32'(mag);
      end
      2: begin
        return 32'($signed($urandom_range(0, 198)) - 99);
      end
      default: begin
        // Powers of ten and their neighbors stress the zero runs inside the text.
        n = $urandom_range(0, DIGITS - 1);
        mag = 1;
        for (k = 0; k < n; k++) begin
          mag = mag * 10;
        end
        mag = mag + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? (32'd0 - 32'(mag)) : 32'(mag);
      end
    endcase
  endfunction

  // Sender: offers queued values, idling at random, holding a value until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
        values_sent <= values_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_values.size() > 0 && !roll_idle()) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_values.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each character taken, stalls at random and once for a long stretch.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("character with no request pending: char_code %0d, last_char %0d",
                 out_tdata[CHAR_W-1:0], out_tlast);
          failures++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata[CHAR_W-1:0] !== want.char_code) begin
            $error("char_code mismatch: expected %0d, actual %0d",
                   want.char_code, out_tdata[CHAR_W-1:0]);
            failures++;
          end
          if (out_tlast !== want.last_char) begin
            $error("last_char mismatch: expected %0d, actual %0d",
                   want.last_char, out_tlast);
            failures++;
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_tready <= 1'b0;
      end else if (!holdoff_done && cycle_count >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !roll_idle();
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int i;
    // Directed values: zero, single digits, length boundaries, both extremes.
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(32'd7000);
    pending_values.push_back(-32'sd12345);
    pending_values.push_back(32'd100005);
    pending_values.push_back(32'd9999999);
    pending_values.push_back(-32'sd10000000);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(32'd1000000009);
    pending_values.push_back(-32'sd999999999);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    for (i = 0; i < RANDOM_VALUES; i++) begin
      pending_values.push_back(random_value());
    end
    values_total = pending_values.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (values_sent != values_total) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d integers (%0d negative) into %0d checked characters,",
             values_total, negatives_sent, chars_checked);
    $display("covering %0d distinct text lengths from 1 to 11 characters.",
             $countones(run_lengths_seen));
    if (failures == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
sv/s2dec_pkg.sv
sv/signed_int_to_decimal_ascii.sv
sv/s2dec_chk.sv
tb/signed_int_to_decimal_ascii_tb.sv
